FILE: hw/rtl/pfrw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the PLL frequency to
// register word block. No dependencies; every other file imports this one.
package pfrw_pkg;

  localparam int MAX_DIVIDER_STEPS = 10;

  localparam int FREQ_W  = 16;
  localparam int WORD_W  = 32;
  localparam int WHOLE_W = 13;                          // 44000 / 10 fits
  localparam int EXP_W   = $clog2(MAX_DIVIDER_STEPS + 1);
  localparam int P_W     = WHOLE_W + MAX_DIVIDER_STEPS;
  // Saturation keeps t * d below 2^16 (whole * d <= 4400 with d <= 64), so
  // x = 16 * t * d fits in 20 bits for any divider search length.
  localparam int X_W     = FREQ_W + 4;
  localparam int QUO_W   = 10;                          // x / 1000 stays below 715
  localparam int REM_W   = 10;
  localparam int MOD_W   = 10;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 30;

  localparam logic [FREQ_W-1:0]  FREQ_MIN  = 16'd350;
  localparam logic [FREQ_W-1:0]  FREQ_MAX  = 16'd44000;
  localparam logic [P_W-1:0]     VCO_LOW   = P_W'(2200);
  localparam logic [P_W-1:0]     VCO_HIGH  = P_W'(4400);
  localparam logic [REM_W:0]     DIVISOR   = (REM_W + 1)'(1000);
  localparam logic [MOD_W-1:0]   MOD_START = MOD_W'(1000);
  localparam logic [FREQ_W-1:0]  RECIP_10  = 16'hCCCD;   // 2^19 / 10, rounded up
  localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd1073742; // 2^30 / 1000, rounded up

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_R1_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R4_ON   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RF_OFF  = 2'd2;

  typedef enum logic [1:0] {
    WSEL_RF_OFF,
    WSEL_R1,
    WSEL_R0,
    WSEL_R4
  } word_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SEARCH,
    ST_DIVIDE,
    ST_RED5,
    ST_RED2,
    ST_EMIT
  } pfrw_state_t;

  typedef struct packed {
    logic [WORD_W-1:0] r1_base_word;
    logic [WORD_W-1:0] r4_on_word;
    logic [WORD_W-1:0] rf_off_word;
  } cfg_regs_t;

  typedef struct packed {
    logic      load;
    logic      scale;
    logic      search_step;
    logic      div_load;
    logic      div_step;
    logic      red5_step;
    logic      red2_step;
    logic      emit_load;
    word_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic search_done;
    logic div_last;
    logic can5;
    logic can2;
  } dp_stat_t;

  // Quotient by five for values below 1000, by reciprocal multiplication.
  function automatic logic [9:0] div5(input logic [9:0] v);
    logic [17:0] prod;
    prod = {8'd0, v} * 18'd205;
    return {2'b00, prod[17:10]};
  endfunction

  function automatic logic [2:0] rem5(input logic [9:0] v);
    logic [9:0] q;
    logic [9:0] r;
    q = div5(v);
    r = v - (q << 2) - q;
    return r[2:0];
  endfunction

  // Exponent modulo seven; the exponent never exceeds 20.
  function automatic logic [2:0] mod7(input logic [EXP_W-1:0] v);
    logic [EXP_W+1:0] w;
    w = (EXP_W + 2)'(v);
    if (w >= (EXP_W + 2)'(14)) begin
      w = w - (EXP_W + 2)'(14);
    end else if (w >= (EXP_W + 2)'(7)) begin
      w = w - (EXP_W + 2)'(7);
    end
    return w[2:0];
  endfunction

endpackage

FILE: hw/rtl/pfrw_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the frequency input and the register
// word output. Depends on pfrw_pkg for the field widths.
interface pfrw_freq_if import pfrw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] freq_tenths_mhz;

  modport source (output valid, output freq_tenths_mhz, input ready);
  modport sink (input valid, input freq_tenths_mhz, output ready);
endinterface

interface pfrw_word_if import pfrw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] reg_word;
  logic              last_word;

  modport source (output valid, output reg_word, output last_word, input ready);
  modport sink (input valid, input reg_word, input last_word, output ready);
endinterface

FILE: hw/rtl/pfrw_datapath.sv
`timescale 1ns / 1ps
// Datapath: saturation, divider search, division by 1000 by reciprocal
// multiplication, fraction reduction and the output word register. Depends on pfrw_pkg.
module pfrw_datapath import pfrw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [FREQ_W-1:0] freq_in,
  input  cfg_regs_t         cfg,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic [WORD_W-1:0] reg_word,
  output logic              last_word
);

  logic [FREQ_W-1:0]  t_sat;
  logic [WHOLE_W-1:0] whole;
  logic [EXP_W-1:0]   expo;
  logic [X_W-1:0]     x_val;
  logic [QUO_W-1:0]   quo;
  logic [REM_W-1:0]   rem;
  logic [MOD_W-1:0]   mod_q;
  logic               div_phase;

  logic [FREQ_W-1:0]      t_clip;
  logic [2*FREQ_W-1:0]    prod;
  logic [P_W-1:0]         p;
  logic [X_W+RECIP_W-1:0] recip_prod;
  logic [X_W-1:0]         rem_full;
  logic [WORD_W-1:0]      word_next;

  always_comb begin
    t_clip = freq_in;
    if (freq_in < FREQ_MIN) begin
      t_clip = FREQ_MIN;
    end else if (freq_in > FREQ_MAX) begin
      t_clip = FREQ_MAX;
    end
  end

  assign prod       = t_sat * RECIP_10;
  assign p          = P_W'(whole) << expo;
  assign recip_prod = (X_W + RECIP_W)'(x_val) * (X_W + RECIP_W)'(RECIP_1000);
  assign rem_full   = x_val - X_W'(quo) * X_W'(DIVISOR);

  assign stat.search_done = ((p >= VCO_LOW) && (p <= VCO_HIGH))
                            || (expo == EXP_W'(MAX_DIVIDER_STEPS));
  assign stat.div_last    = div_phase;
  assign stat.can5        = (rem5(rem) == 3'd0) && (rem5(mod_q) == 3'd0);
  assign stat.can2        = !rem[0] && !mod_q[0];

  always_comb begin
    unique case (cmd.sel)
      WSEL_RF_OFF: word_next = cfg.rf_off_word;
      WSEL_R1:     word_next = cfg.r1_base_word + (WORD_W'(mod_q) << 3);
      WSEL_R0:     word_next = (WORD_W'(quo) << 15) + (WORD_W'(rem) << 3);
      WSEL_R4:     word_next = cfg.r4_on_word + (WORD_W'(mod7(expo)) << 20);
      default:     word_next = cfg.rf_off_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_sat <= t_clip;
      expo  <= '0;
    end
    // The product is exact for any 16-bit value, so this is t / 10.
    if (cmd.scale) begin
      whole <= prod[2*FREQ_W-1 -: WHOLE_W];
    end
    if (cmd.search_step) begin
      expo <= expo + EXP_W'(1);
    end
    if (cmd.div_load) begin
      x_val     <= X_W'(t_sat) << (expo + EXP_W'(4));
      mod_q     <= MOD_START;
      div_phase <= 1'b0;
    end
    // The first step takes the quotient from the reciprocal product, the
    // second the remainder left after subtracting the quotient times 1000.
    if (cmd.div_step) begin
      if (div_phase) begin
        rem <= rem_full[REM_W-1:0];
      end else begin
        quo <= recip_prod[RECIP_SHIFT +: QUO_W];
      end
      div_phase <= 1'b1;
    end
    if (cmd.red5_step) begin
      rem   <= div5(rem);
      mod_q <= div5(mod_q);
    end
    if (cmd.red2_step) begin
      rem   <= rem >> 1;
      mod_q <= mod_q >> 1;
    end
    if (cmd.emit_load) begin
      reg_word  <= word_next;
      last_word <= (cmd.sel == WSEL_R4);
    end
  end

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.search_step |-> (expo != EXP_W'(MAX_DIVIDER_STEPS)))
    else $error("divider search stepped past its limit");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && div_phase) |-> (rem_full < X_W'(DIVISOR)))
    else $error("division remainder reached the divisor");

  a_frac_below_mod: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (rem < mod_q))
    else $error("reduced fraction not below the modulus");

  a_reduce_stops: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load && (cmd.sel == WSEL_RF_OFF)) |-> (!stat.can5 && !stat.can2))
    else $error("words emitted before the fraction was fully reduced");

endmodule

FILE: hw/rtl/pfrw_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing the datapath through one frequency
// and the four word transfers. Depends on pfrw_pkg.
module pfrw_ctrl import pfrw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  pfrw_state_t state;
  pfrw_state_t state_next;
  word_sel_t   word_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      word_idx <= WSEL_RF_OFF;
    end else begin
      state <= state_next;
      if (cmd.emit_load) begin
        word_idx <= cmd.sel;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_SEARCH;
      ST_SEARCH: if (stat.search_done) state_next = ST_DIVIDE;
      ST_DIVIDE: if (stat.div_last) state_next = ST_RED5;
      ST_RED5:   if (!stat.can5) state_next = ST_RED2;
      ST_RED2:   if (!stat.can2) state_next = ST_EMIT;
      ST_EMIT:   if (out_ready && (word_idx == WSEL_R4)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_EMIT);
    cmd       = '0;
    cmd.sel   = WSEL_RF_OFF;
    unique case (state)
      ST_IDLE:   cmd.load = in_valid;
      ST_SCALE:  cmd.scale = 1'b1;
      ST_SEARCH: begin
        cmd.search_step = !stat.search_done;
        cmd.div_load    = stat.search_done;
      end
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_RED5:   cmd.red5_step = stat.can5;
      ST_RED2:   begin
        cmd.red2_step = stat.can2;
        cmd.emit_load = !stat.can2;
      end
      ST_EMIT:   begin
        // The next word is loaded in the same cycle as the current transfer.
        cmd.emit_load = out_ready && (word_idx != WSEL_R4);
        cmd.sel       = word_sel_t'(word_idx + 2'd1);
      end
      default:   cmd = '0;
    endcase
  end

endmodule

FILE: hw/rtl/pll_frequency_to_register_words.sv
`timescale 1ns / 1ps
// Top level: configuration registers, controller and datapath.
// Depends on pfrw_pkg, pfrw_if, pfrw_ctrl and pfrw_datapath.
//
//  Channel  Direction  Contents
//  freq     in         freq_tenths_mhz[15:0]
//  words    out        reg_word[31:0], last_word
//  cfg_*    in         write enable, index[1:0], data[31:0]
//
// One frequency is taken at a time and yields four word transfers.
// From the transfer in to the first word the block scales the frequency,
// runs the divider search, divides by 1000 (quotient, then remainder) and
// reduces the fraction by five, then by two; the search and the reduction
// run longer or shorter depending on the frequency.
// Reset (synchronous) returns the controller to idle and the configuration
// registers to their defaults; a stalled sink simply holds the current word.
module pll_frequency_to_register_words import pfrw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  pfrw_freq_if.sink            freq,
  pfrw_word_if.source          words
);

  cfg_regs_t cfg;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.r1_base_word <= WORD_W'(1);
      cfg.r4_on_word   <= WORD_W'(4);
      cfg.rf_off_word  <= WORD_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_R1_BASE: cfg.r1_base_word <= cfg_wdata;
        CFG_R4_ON:   cfg.r4_on_word   <= cfg_wdata;
        CFG_RF_OFF:  cfg.rf_off_word  <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  pfrw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (freq.valid),
    .in_ready  (freq.ready),
    .out_valid (words.valid),
    .out_ready (words.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfrw_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .freq_in   (freq.freq_tenths_mhz),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .reg_word  (words.reg_word),
    .last_word (words.last_word)
  );

endmodule

FILE: dv/pll_frequency_to_register_words_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pll_frequency_to_register_words: directed and
// random frequencies under stalls. Depends on pfrw_pkg, pfrw_if and the RTL.
module pll_frequency_to_register_words_tb;
  import pfrw_pkg::*;

  localparam int SETTLE_CYCLES = 60;   // longer than one item's latency
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 112;  // per idling phase
  localparam int VCO_MIN_MHZ   = 2200;
  localparam int VCO_MAX_MHZ   = 4400;
  localparam int PFD_SCALE     = 16;   // 6.25 MHz steps in tenths of a MHz
  localparam int DIV_FIELD_MOD = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              last;
  } reg_word_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0] cfg_wdata;

  pfrw_freq_if freq_ch ();
  pfrw_word_if word_ch ();

  pll_frequency_to_register_words DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .freq      (freq_ch),
    .words     (word_ch)
  );

  // Local copy of the configuration registers.
  logic [WORD_W-1:0] r1_base;
  logic [WORD_W-1:0] r4_on;
  logic [WORD_W-1:0] rf_off;

  reg_word_t pending_words[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Works out the four register words for one frequency and queues them.
  function automatic void compute_register_words(input logic [FREQ_W-1:0] f);
    logic [63:0] t;
    logic [63:0] whole;
    logic [63:0] div;
    logic [63:0] x;
    logic [63:0] int_part;
    logic [63:0] frac;
    logic [63:0] modulus;
    int unsigned expo;
    reg_word_t w;
    t = 64'(f);
    if (t < 64'(FREQ_MIN)) t = 64'(FREQ_MIN);
    if (t > 64'(FREQ_MAX)) t = 64'(FREQ_MAX);
    whole = t / 10;
    div = 1;
    expo = 0;
    for (int s = 0; s < MAX_DIVIDER_STEPS; s++) begin
      if (whole * div >= VCO_MIN_MHZ && whole * div <= VCO_MAX_MHZ) break;
      expo++;
      div = div << 1;
    end
    x = t * div * PFD_SCALE;
    int_part = x / 1000;
    frac = x % 1000;
    modulus = 1000;
    while (frac % 5 == 0 && modulus % 5 == 0) begin
      frac = frac / 5;
      modulus = modulus / 5;
    end
    while (frac % 2 == 0 && modulus % 2 == 0) begin
      frac = frac / 2;
      modulus = modulus / 2;
    end
    w.word = rf_off;
    w.last = 1'b0;
    pending_words.push_back(w);
    w.word = r1_base + WORD_W'(modulus << 3);
    pending_words.push_back(w);
    w.word = WORD_W'((int_part << 15) + (frac << 3));
    pending_words.push_back(w);
    w.word = r4_on + WORD_W'(64'(expo % DIV_FIELD_MOD) << 20);
    w.last = 1'b1;
    pending_words.push_back(w);
  endfunction

  function automatic logic [FREQ_W-1:0] random_freq();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return FREQ_W'($urandom_range(44000, 350));
    if (pick < 85) return FREQ_W'($urandom_range(360, 330));
    if (pick < 90) return FREQ_W'($urandom_range(44020, 43980));
    return FREQ_W'($urandom_range(65535));
  endfunction

  task automatic send_freq(input logic [FREQ_W-1:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      freq_ch.valid <= 1'b0;
      @(posedge clk);
    end
    freq_ch.valid <= 1'b1;
    freq_ch.freq_tenths_mhz <= f;
    do @(posedge clk); while (!freq_ch.ready);
    compute_register_words(f);
  endtask

  // Register writes are only made once every word has been collected.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_R1_BASE: r1_base = data;
      CFG_R4_ON:   r4_on = data;
      CFG_RF_OFF:  rf_off = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    freq_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_defaults();
    logic [FREQ_W-1:0] freqs[$];
    freqs = {16'd0, 16'd349, 16'd350, 16'd351, 16'd625, 16'd1234, 16'd4409,
             16'd10000, 16'd21999, 16'd22000, 16'd22001, 16'd44000, 16'd44001,
             16'd65535};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (freqs[i]) send_freq(freqs[i]);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_cfg(CFG_R1_BASE, '1);
    write_cfg(CFG_R4_ON, '1);
    write_cfg(CFG_RF_OFF, '1);
    send_freq(16'd350);
    send_freq(16'd44000);
    send_freq(16'd12345);
    wait_idle();
    write_cfg(CFG_R1_BASE, '0);
    write_cfg(CFG_R4_ON, '0);
    write_cfg(CFG_RF_OFF, '0);
    send_freq(16'd625);
    send_freq(16'd65535);
    wait_idle();
    // A write to the spare index must leave every register alone.
    write_cfg(CFG_UNUSED, '1);
    send_freq(16'd5000);
    wait_idle();
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct);
    write_cfg(CFG_R1_BASE, $urandom);
    write_cfg(CFG_R4_ON, $urandom);
    write_cfg(CFG_RF_OFF, $urandom);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_ITEMS) send_freq(random_freq());
    wait_idle();
  endtask

  // The receiver stops for a long stretch while frequencies keep coming,
  // so the block fills and holds its input off.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_seq = hold_seq + 1;
    repeat (6) send_freq(random_freq());
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      word_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      word_ch.ready <= 1'b0;
    end else begin
      word_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_words
    reg_word_t want;
    if (!rst && word_ch.valid && word_ch.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word transfer, actual %h last %b", $time,
                 word_ch.reg_word, word_ch.last_word);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (word_ch.reg_word !== want.word) begin
          $display("%0t: reg_word mismatch, expected %h, actual %h", $time,
                   want.word, word_ch.reg_word);
          errors++;
        end
        if (word_ch.last_word !== want.last) begin
          $display("%0t: last_word mismatch, expected %b, actual %b", $time,
                   want.last, word_ch.last_word);
          errors++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CFG_R1_BASE;
    cfg_wdata <= '0;
    freq_ch.valid <= 1'b0;
    freq_ch.freq_tenths_mhz <= '0;
    r1_base = 32'd1;
    r4_on = 32'd4;
    rf_off = 32'd4;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_defaults();
    test_register_extremes();
    test_random_phase(26, 84);
    test_random_phase(84, 26);
    test_random_phase(0, 0);
    test_backpressure();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pfrw_pkg.sv
hw/rtl/pfrw_if.sv
hw/rtl/pfrw_datapath.sv
hw/rtl/pfrw_ctrl.sv
hw/rtl/pll_frequency_to_register_words.sv
dv/pll_frequency_to_register_words_tb.sv
